FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is disabled while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/adp_pkg.sv
// Types and constants of the ASCII decimal number parser.
`default_nettype none
package adp_pkg;

  localparam int MagWidth  = 31;
  localparam int FracWidth = 4;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [MagWidth-1:0]  MAG_MAX  = {MagWidth{1'b1}};
  localparam logic [FracWidth-1:0] FRAC_MAX = {FracWidth{1'b1}};

  typedef struct packed {
    logic [7:0] char_byte;
    logic       timed_out;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]    value;
    logic [FracWidth-1:0]  fraction_digits;
    logic                  number_found;
  } out_item_t;

  typedef struct packed {
    logic                 in_number;
    logic                 is_negative;
    logic [MagWidth-1:0]  accumulator;
    logic                 point_seen;
    logic [FracWidth-1:0] fraction_count;
  } parse_state_t;

  typedef struct packed {
    logic      emit;
    out_item_t result;
  } step_out_t;

endpackage
`default_nettype wire

FILE: hdl/ascii_decimal_number_parser.sv
// Top level of the ASCII decimal number parser.
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one ASCII byte or a
//   timeout marker per transaction. The result channel (out_valid, out_ready,
//   out_data) carries a signed mantissa, its count of fraction digits and a
//   found flag. The configuration channel (cfg_valid, cfg_ready, cfg_data) sets
//   fraction_mode and is always ready; write it only while the block is idle.
//   A byte is held in the input register, processed by the combinational parse
//   step and, when it ends a number or is a timeout, loaded into the result
//   register, from which it is shown to the receiver.
//   One byte is taken every cycle, but for the stall below; the rate is set by
//   the single multiply by ten and add with saturation between the input and
//   result registers. When the receiver stalls, the result register holds its
//   transaction and bytes that produce no result still pass; a byte that would
//   produce a second result waits in the input register and in_ready drops.
//   Reset clears both registers' valid flags, the parse state and the mode.
`default_nettype none
module ascii_decimal_number_parser import adp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic         in_vld_r;
  in_item_t     in_item_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         mode_r;
  step_out_t    step;
  logic         out_can_load;
  logic         proc_go;

  assign cfg_ready = 1'b1;
  assign proc_go   = in_vld_r && (!step.emit || out_can_load);
  assign in_ready  = !in_vld_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (proc_go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (proc_go) begin
      state_r <= state_nxt;
    end
  end

  adp_core u_core (
    .state         (state_r),
    .item          (in_item_r),
    .fraction_mode (mode_r),
    .state_nxt     (state_nxt),
    .step          (step)
  );

  adp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc_go && step.emit),
    .load_data (step.result),
    .can_load  (out_can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: hdl/adp_core.sv
// Combinational parse step: next state and optional result for one byte.
`default_nettype none
module adp_core import adp_pkg::*; (
  input  parse_state_t state,
  input  in_item_t     item,
  input  logic         fraction_mode,
  output parse_state_t state_nxt,
  output step_out_t    step
);

  function automatic parse_state_t add_digit(parse_state_t s, logic [3:0] d);
    parse_state_t r;
    logic [MagWidth+3:0] sum;
    r = s;
    sum = ({4'b0, s.accumulator} << 3) + ({4'b0, s.accumulator} << 1)
          + {{MagWidth{1'b0}}, d};
    if (!(s.point_seen && s.fraction_count == FRAC_MAX)) begin
      if (s.point_seen) begin
        r.fraction_count = s.fraction_count + 1'b1;
      end
      r.accumulator = (sum > {4'b0, MAG_MAX}) ? MAG_MAX : sum[MagWidth-1:0];
    end
    return r;
  endfunction

  function automatic parse_state_t try_start(logic [7:0] c, logic dig, logic [3:0] d);
    parse_state_t r;
    r = '0;
    if (c == CHAR_MINUS) begin
      r.in_number   = 1'b1;
      r.is_negative = 1'b1;
    end else if (dig) begin
      r = add_digit(r, d);
      r.in_number = 1'b1;
    end
    return r;
  endfunction

  logic [7:0]  diff;
  logic [3:0]  digit;
  logic        is_digit;
  logic [31:0] mag;

  assign diff     = item.char_byte - CHAR_ZERO;
  assign digit    = diff[3:0];
  assign is_digit = (item.char_byte >= CHAR_ZERO) && (item.char_byte <= CHAR_NINE);
  assign mag      = {1'b0, state.accumulator};

  always_comb begin
    step.result.value           = $signed(state.is_negative ? (32'd0 - mag) : mag);
    step.result.fraction_digits = state.fraction_count;
    step.result.number_found    = state.in_number;
    step.emit                   = 1'b0;
    state_nxt                   = state;
    if (item.timed_out) begin
      step.emit = 1'b1;
      state_nxt = '0;
    end else if (!state.in_number) begin
      state_nxt = try_start(item.char_byte, is_digit, digit);
    end else if (is_digit) begin
      state_nxt = add_digit(state, digit);
    end else if (item.char_byte == CHAR_POINT && fraction_mode && !state.point_seen) begin
      state_nxt.point_seen = 1'b1;
    end else begin
      // The byte ends the number and is looked at again as a new start.
      step.emit = 1'b1;
      state_nxt = try_start(item.char_byte, is_digit, digit);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/adp_out_reg.sv
// Result register with valid and ready toward the receiver.
`default_nettype none
module adp_out_reg import adp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t load_data,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r;
  out_item_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/adp_checker.sv
// Port-level assertions for the ASCII decimal number parser, with its bind.
`default_nettype none
`include "assert_macros.svh"
module adp_checker import adp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result transaction keeps its payload.
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // A timeout while skipping reports an all-zero number.
  `ASSERT_CLK(a_not_found_zero, out_valid && !out_data.number_found |-> out_data.value == 32'sd0 && out_data.fraction_digits == 4'd0, "nonzero result without a number")

  // The magnitude saturates, so the most negative code never appears.
  `ASSERT_CLK(a_sat_value, out_valid |-> out_data.value != 32'sh8000_0000, "magnitude not saturated")

  // Reset empties the result register.
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind ascii_decimal_number_parser adp_checker u_adp_checker (.*);
`default_nettype wire

FILE: tb/ascii_decimal_number_parser_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the ASCII decimal number parser: directed rows, then random numbers.
module ascii_decimal_number_parser_test;
  import adp_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int LongHold = 120;
  localparam int HoldAtResult = 20;
  localparam int ItemTarget = 1100;
  localparam int PhaseItems = 180;
  localparam int DrainCycles = 4;
  localparam int NumRows = 23;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    in_item_t  item;
    logic      mode;
    logic      fixed;
    out_item_t want;
  } row_t;

  localparam out_item_t NO_RESULT = '0;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  // Parser state and mode as the testbench expects them to be.
  parse_state_t scan = '0;
  logic         point_mode = 1'b0;
  out_item_t    parsed_q[$];

  int sent_cnt = 0;
  int fail_cnt = 0;
  int quiet_cycles = 0;

  // Rows with a typed result are checked against that value, the rest against the predictor.
  row_t dir_rows [NumRows] = '{
    '{ROW_BYTE, '{8'h00, 1'b1}, 1'b0, 1'b1, '{32'sd0, 4'd0, 1'b0}},
    '{ROW_BYTE, '{CHAR_MINUS, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{8'h00, 1'b1}, 1'b0, 1'b1, '{32'sd0, 4'd0, 1'b1}},
    '{ROW_BYTE, '{8'hFF, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{8'h00, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{8'h37, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{CHAR_MINUS, 1'b0}, 1'b0, 1'b1, '{32'sd7, 4'd0, 1'b1}},
    '{ROW_BYTE, '{CHAR_ZERO, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{8'h33, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{CHAR_POINT, 1'b0}, 1'b0, 1'b1, '{-32'sd3, 4'd0, 1'b1}},
    '{ROW_BYTE, '{CHAR_MINUS, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{CHAR_ZERO, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{8'h41, 1'b1}, 1'b0, 1'b1, '{32'sd0, 4'd0, 1'b1}},
    '{ROW_CFG, '{8'h00, 1'b0}, 1'b1, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{CHAR_MINUS, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{8'h31, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{CHAR_POINT, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{8'h32, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{8'h35, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{CHAR_POINT, 1'b0}, 1'b0, 1'b1, '{-32'sd125, 4'd2, 1'b1}},
    '{ROW_BYTE, '{8'h38, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{CHAR_POINT, 1'b0}, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, '{8'h00, 1'b1}, 1'b0, 1'b1, '{32'sd8, 4'd0, 1'b1}}
  };

  ascii_decimal_number_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Every 64 transactions, one window in four runs with no idle cycles at all.
  function automatic int draw_gap(int n);
    return ((n / 64) % 4 == 3) ? 0 : int'($urandom_range(0, 3));
  endfunction

  function automatic in_item_t byte_item(logic [7:0] c, logic tmo);
    in_item_t it;
    it.char_byte = c;
    it.timed_out = tmo;
    return it;
  endfunction

  function automatic logic [7:0] rand_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic void take_digit(logic [3:0] d);
    logic [35:0] grown;
    if (scan.point_seen) begin
      // Digits past a full fraction count are swallowed without effect.
      if (scan.fraction_count == FRAC_MAX) return;
      scan.fraction_count = scan.fraction_count + 4'd1;
    end
    grown = 36'(scan.accumulator) * 36'd10 + 36'(d);
    scan.accumulator = (grown > 36'(MAG_MAX)) ? MAG_MAX : grown[MagWidth-1:0];
  endfunction

  function automatic void parse_byte(input in_item_t it, output logic emits,
                                     output out_item_t res);
    logic        restart;
    logic        is_num_digit;
    logic [31:0] mag;
    mag = {1'b0, scan.accumulator};
    res.value = scan.is_negative ? (32'd0 - mag) : mag;
    res.fraction_digits = scan.fraction_count;
    res.number_found = scan.in_number;
    emits = 1'b0;
    restart = 1'b0;
    is_num_digit = (it.char_byte >= CHAR_ZERO) && (it.char_byte <= CHAR_NINE);
    if (it.timed_out) begin
      emits = 1'b1;
      scan = '0;
    end else if (!scan.in_number) begin
      restart = 1'b1;
    end else if (is_num_digit) begin
      take_digit(4'(it.char_byte - CHAR_ZERO));
    end else if (it.char_byte == CHAR_POINT && point_mode && !scan.point_seen) begin
      scan.point_seen = 1'b1;
    end else begin
      // Any other byte closes the number and is looked at again as a new start.
      emits = 1'b1;
      scan = '0;
      restart = 1'b1;
    end
    if (restart) begin
      if (it.char_byte == CHAR_MINUS) begin
        scan = '0;
        scan.in_number = 1'b1;
        scan.is_negative = 1'b1;
      end else if (is_num_digit) begin
        scan = '0;
        scan.in_number = 1'b1;
        take_digit(4'(it.char_byte - CHAR_ZERO));
      end
    end
  endfunction

  task automatic send_byte(input in_item_t it, input logic fixed, input out_item_t want);
    logic         emits;
    out_item_t    res;
    int           gap;
    gap = draw_gap(sent_cnt);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    parse_byte(it, emits, res);
    if (emits || fixed) parsed_q.push_back(fixed ? want : res);
  endtask

  // The mode is only changed once every pending result has come out.
  task automatic write_mode(input logic mode);
    in_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    point_mode = mode;
  endtask

  task automatic send_number();
    in_item_t seq[$];
    int       len;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4))
        seq.push_back(byte_item(8'($urandom), $urandom_range(0, 7) == 0));
    end else begin
      repeat ($urandom_range(0, 2)) seq.push_back(byte_item(8'($urandom), 1'b0));
      if ($urandom_range(0, 2) == 0) seq.push_back(byte_item(CHAR_MINUS, 1'b0));
      // Now and then a long run, to drive the magnitude into saturation.
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
      repeat (len) seq.push_back(byte_item(rand_digit(), 1'b0));
      if ($urandom_range(0, 1) == 1) begin
        seq.push_back(byte_item(CHAR_POINT, 1'b0));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
        repeat (len) seq.push_back(byte_item(rand_digit(), 1'b0));
      end
      case ($urandom_range(0, 4))
        0: seq.push_back(byte_item(8'($urandom), 1'b1));
        1: seq.push_back(byte_item(CHAR_MINUS, 1'b0));
        2: seq.push_back(byte_item(CHAR_POINT, 1'b0));
        3: seq.push_back(byte_item(CHAR_SPACE, 1'b0));
        default: seq.push_back(byte_item(8'($urandom), 1'b0));
      endcase
    end
    foreach (seq[i]) send_byte(seq[i], 1'b0, NO_RESULT);
  endtask

  initial begin
    int target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_mode(dir_rows[i].mode);
      else send_byte(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
    end
    // Phases alternate the mode; a phase may start while a number is half parsed.
    for (int p = 0; sent_cnt < ItemTarget; p++) begin
      write_mode(p[0]);
      target = sent_cnt + PhaseItems;
      while (sent_cnt < target) send_number();
    end
    in_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("ascii_decimal_number_parser verification clean");
    end else begin
      $display("ascii_decimal_number_parser verification failed");
    end
    $finish;
  end

  // Result side: short random stalls, and one long hold-off so that the block backs up.
  initial begin
    int hold;
    int got;
    got = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = (got == HoldAtResult) ? LongHold : draw_gap(got);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (parsed_q.size() == 0) begin
        $error("result transaction with nothing pending: value %0d", out_data.value);
        fail_cnt++;
      end else begin
        want = parsed_q.pop_front();
        if (out_data.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_data.value);
          fail_cnt++;
        end
        if (out_data.fraction_digits !== want.fraction_digits) begin
          $error("fraction_digits: expected %0d, got %0d",
                 want.fraction_digits, out_data.fraction_digits);
          fail_cnt++;
        end
        if (out_data.number_found !== want.number_found) begin
          $error("number_found: expected %0b, got %0b",
                 want.number_found, out_data.number_found);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("ascii_decimal_number_parser verification failed");
      $finish;
    end
  end

endmodule
